// ===== rtl/sunras_pkg.sv =====
// Shared types and constants for the Sun rasterfile RLE pixel decoder.
// No dependencies; every other file of the block but sunras_palette_ram imports this package.
`default_nettype none

package sunras_pkg;

    localparam int PAL_DEPTH  = 256;
    localparam int PAL_AW     = $clog2(PAL_DEPTH);
    localparam int PAL_DW     = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    localparam logic [8:0]  PAL_SIZE_MAX = 9'(PAL_DEPTH);
    localparam logic [12:0] MAX_WIDTH    = 13'd4096;
    localparam logic [12:0] MAX_HEIGHT   = 13'd4096;
    localparam logic [7:0]  ESC_BYTE     = 8'h80;
    localparam logic [7:0]  ESC_LITERAL  = 8'h00;
    localparam logic [7:0]  ESC_PAIR     = 8'h01;

    typedef enum logic [2:0] {
        CFG_INDEXED_MODE = 3'd0,
        CFG_RLE_ENABLE   = 3'd1,
        CFG_IMAGE_WIDTH  = 3'd2,
        CFG_IMAGE_HEIGHT = 3'd3,
        CFG_PALETTE_SIZE = 3'd4
    } cfg_index_t;

    typedef enum logic [1:0] {
        FUNC_PAL_WRITE = 2'd0,
        FUNC_DATA      = 2'd1,
        FUNC_START     = 2'd2,
        FUNC_IDLE      = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ERR_NONE   = 2'd0,
        ERR_INDEX  = 2'd1,
        ERR_ESCAPE = 2'd2
    } err_code_t;

    typedef enum logic [1:0] {
        ESC_IDLE = 2'd0,
        ESC_CODE = 2'd1,
        ESC_ONE  = 2'd2,
        ESC_RUN  = 2'd3
    } esc_phase_t;

    typedef struct packed {
        logic [1:0] func;
        logic       byte_valid;
        logic [7:0] data_byte;
        logic [7:0] entry_index;
        logic [7:0] entry_red;
        logic [7:0] entry_green;
        logic [7:0] entry_blue;
    } req_t;

    typedef struct packed {
        logic       byte_taken;
        logic       pixel_valid;
        logic [7:0] pixel_red;
        logic [7:0] pixel_green;
        logic [7:0] pixel_blue;
        logic       last_pixel;
        logic [1:0] error_code;
    } rsp_t;

    // decode result waiting for the palette read data
    typedef struct packed {
        logic       byte_taken;
        logic       pixel_valid;
        logic       from_pal;
        logic       mono_white;
        logic       last_pixel;
        logic [1:0] error_code;
    } s1_t;

endpackage

`default_nettype wire

// ===== rtl/sunras_if.sv =====
// Request and response channel interfaces of the rasterfile decoder.
// Depends on sunras_pkg for the payload types.
`default_nettype none

interface sunras_req_if;
    import sunras_pkg::*;
    logic valid;
    logic ready;
    req_t payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface sunras_rsp_if;
    import sunras_pkg::*;
    logic valid;
    logic ready;
    rsp_t payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/sunras_palette_ram.sv =====
// Generic simple dual-port synchronous RAM with a registered read.
// Holds the color palette; no dependencies.
`default_nettype none

module sunras_palette_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 24,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/sunras_decode.sv =====
// Configuration registers, escape/run/mono state and row/column counters.
// Issues palette reads and writes; depends on sunras_pkg.
`default_nettype none

module sunras_decode (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [sunras_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [sunras_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                                accept,
    input  sunras_pkg::req_t                    req,
    output logic                                pal_we,
    output logic [sunras_pkg::PAL_AW-1:0]       pal_waddr,
    output logic [sunras_pkg::PAL_DW-1:0]       pal_wdata,
    output logic                                pal_re,
    output logic [sunras_pkg::PAL_AW-1:0]       pal_raddr,
    output sunras_pkg::s1_t                     s1_info
);

    import sunras_pkg::*;

    logic        indexed_reg;
    logic        rle_reg;
    logic [12:0] width_reg;
    logic [12:0] height_reg;
    logic [8:0]  psize_reg;

    esc_phase_t  esc_phase_reg, esc_phase_next, esc_phase_base;
    logic [7:0]  esc_count_reg, esc_count_next, esc_count_base;
    logic [7:0]  run_rem_reg, run_rem_next;
    logic [7:0]  run_val_reg, run_val_next;
    logic [7:0]  mono_byte_reg, mono_byte_next;
    logic [3:0]  mono_left_reg, mono_left_next;
    logic [11:0] pos_reg, pos_next;
    logic [12:0] col_reg, col_next;
    logic [11:0] row_reg, row_next;
    logic [1:0]  err_reg, err_next;
    logic        done_reg, done_next;

    logic [12:0] w_eff, h_eff, rb, pb, pos_inc, col_inc, row_inc, col_room;
    logic [8:0]  ps_eff;
    logic [3:0]  mono_n;
    logic        row_data;

    logic        rle_dec_en, rle_run_load, rle_bad;
    logic [7:0]  rle_dec_b, rle_run_rem;

    logic        data_go, dec_en, emit_en, adv, err_raise;
    logic [7:0]  dec_b, emit_byte;
    logic [3:0]  emit_left;
    logic [1:0]  err_new;
    logic        taken, pv, from_pal, white, last;

    // effective geometry
    assign w_eff = (width_reg == '0) ? 13'd1 :
                   ((width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg);
    assign h_eff = (height_reg == '0) ? 13'd1 :
                   ((height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg);
    assign ps_eff = (psize_reg > PAL_SIZE_MAX) ? PAL_SIZE_MAX : psize_reg;
    assign rb = indexed_reg ? w_eff : 13'((w_eff + 13'd7) >> 3);
    assign pb = rb + {12'd0, rb[0]};
    assign pos_inc  = {1'b0, pos_reg} + 13'd1;
    assign row_data = ({1'b0, pos_reg} < rb);
    assign col_inc  = col_reg + 13'd1;
    assign row_inc  = {1'b0, row_reg} + 13'd1;
    assign col_room = w_eff - col_reg;
    assign mono_n   = (col_room > 13'd8) ? 4'd8 : col_room[3:0];

    // escape sequence: next phase
    always_comb
    begin
        esc_phase_base = esc_phase_reg;
        esc_count_base = esc_count_reg;
        case (esc_phase_reg)
            ESC_IDLE:
            begin
                if (req.data_byte == ESC_BYTE)
                begin
                    esc_phase_base = ESC_CODE;
                end
            end
            ESC_CODE:
            begin
                if (req.data_byte == ESC_LITERAL)
                begin
                    esc_phase_base = ESC_IDLE;
                end
                else if (req.data_byte == ESC_PAIR)
                begin
                    esc_phase_base = ESC_ONE;
                end
                else
                begin
                    esc_phase_base = ESC_RUN;
                    esc_count_base = req.data_byte;
                end
            end
            ESC_ONE:  esc_phase_base = ESC_IDLE;
            ESC_RUN:  esc_phase_base = ESC_IDLE;
            default:  esc_phase_base = ESC_IDLE;
        endcase
    end

    // escape sequence: decoded byte and run load
    always_comb
    begin
        rle_dec_en   = 1'b0;
        rle_dec_b    = req.data_byte;
        rle_run_load = 1'b0;
        rle_run_rem  = esc_count_reg;
        rle_bad      = 1'b0;
        case (esc_phase_reg)
            ESC_IDLE:
            begin
                rle_dec_en = (req.data_byte != ESC_BYTE);
            end
            ESC_CODE:
            begin
                if (req.data_byte == ESC_LITERAL)
                begin
                    rle_dec_en = 1'b1;
                    rle_dec_b  = ESC_BYTE;
                end
            end
            ESC_ONE:
            begin
                if (req.data_byte != ESC_BYTE)
                begin
                    rle_bad = 1'b1;
                end
                else
                begin
                    rle_run_load = 1'b1;
                    rle_run_rem  = 8'd1;
                    rle_dec_en   = 1'b1;
                    rle_dec_b    = ESC_BYTE;
                end
            end
            ESC_RUN:
            begin
                rle_run_load = 1'b1;
                rle_dec_en   = 1'b1;
            end
            default:
            begin
                rle_dec_en = 1'b0;
            end
        endcase
    end

    assign data_go = accept && (req.func == FUNC_DATA) && !done_reg && (err_reg == ERR_NONE);

    always_comb
    begin
        esc_phase_next = esc_phase_reg;
        esc_count_next = esc_count_reg;
        run_rem_next   = run_rem_reg;
        run_val_next   = run_val_reg;
        mono_byte_next = mono_byte_reg;
        mono_left_next = mono_left_reg;
        pos_next       = pos_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        err_next       = err_reg;
        done_next      = done_reg;
        dec_en         = 1'b0;
        dec_b          = run_val_reg;
        emit_en        = 1'b0;
        emit_byte      = mono_byte_reg;
        emit_left      = mono_left_reg;
        adv            = 1'b0;
        err_raise      = 1'b0;
        err_new        = ERR_NONE;
        taken          = 1'b0;
        pv             = 1'b0;
        from_pal       = 1'b0;
        white          = 1'b0;
        last           = 1'b0;

        if (data_go)
        begin
            // pending mono bits first, then run copies, then the offered byte
            if (mono_left_reg != '0)
            begin
                emit_en = 1'b1;
            end
            else if (run_rem_reg != '0)
            begin
                run_rem_next = run_rem_reg - 8'd1;
                dec_en       = 1'b1;
            end
            else if (req.byte_valid)
            begin
                taken = 1'b1;
                if (rle_reg)
                begin
                    esc_phase_next = esc_phase_base;
                    esc_count_next = esc_count_base;
                    if (rle_run_load)
                    begin
                        run_val_next = rle_dec_b;
                        run_rem_next = rle_run_rem;
                    end
                    if (rle_bad)
                    begin
                        err_raise = 1'b1;
                        err_new   = ERR_ESCAPE;
                    end
                    dec_en = rle_dec_en;
                    dec_b  = rle_dec_b;
                end
                else
                begin
                    dec_en = 1'b1;
                    dec_b  = req.data_byte;
                end
            end

            if (dec_en)
            begin
                pos_next = (pos_inc >= pb) ? '0 : pos_inc[11:0];
                if (row_data && (col_reg < w_eff))
                begin
                    if (indexed_reg)
                    begin
                        if ({1'b0, dec_b} >= ps_eff)
                        begin
                            err_raise = 1'b1;
                            err_new   = ERR_INDEX;
                        end
                        else
                        begin
                            pv       = 1'b1;
                            from_pal = 1'b1;
                            adv      = 1'b1;
                        end
                    end
                    else
                    begin
                        emit_en   = 1'b1;
                        emit_byte = dec_b;
                        emit_left = mono_n;
                    end
                end
            end

            if (emit_en)
            begin
                pv             = 1'b1;
                white          = !emit_byte[7];
                mono_byte_next = {emit_byte[6:0], 1'b0};
                mono_left_next = emit_left - 4'd1;
                adv            = 1'b1;
            end

            if (adv)
            begin
                if (col_inc >= w_eff)
                begin
                    if (row_inc < h_eff)
                    begin
                        row_next = row_reg + 12'd1;
                        col_next = '0;
                    end
                    else
                    begin
                        col_next = w_eff;
                        last     = 1'b1;
                    end
                end
                else
                begin
                    col_next = col_inc;
                end
            end

            if (err_raise)
            begin
                err_next       = err_new;
                run_rem_next   = '0;
                mono_left_next = '0;
                esc_phase_next = ESC_IDLE;
            end

            // end of image once the last pixel and the trailing pad are through
            if ((err_next == ERR_NONE) && (({1'b0, row_next} + 13'd1) >= h_eff) &&
                (col_next >= w_eff) && (pos_next == '0) && (mono_left_next == '0))
            begin
                run_rem_next   = '0;
                esc_phase_next = ESC_IDLE;
                done_next      = 1'b1;
            end
        end
        else if (accept && (req.func == FUNC_START))
        begin
            esc_phase_next = ESC_IDLE;
            esc_count_next = '0;
            run_rem_next   = '0;
            run_val_next   = '0;
            mono_byte_next = '0;
            mono_left_next = '0;
            pos_next       = '0;
            col_next       = '0;
            row_next       = '0;
            err_next       = ERR_NONE;
            done_next      = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            indexed_reg <= 1'b1;
            rle_reg     <= 1'b0;
            width_reg   <= 13'd1;
            height_reg  <= 13'd1;
            psize_reg   <= PAL_SIZE_MAX;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_INDEXED_MODE: indexed_reg <= cfg_wdata[0];
                CFG_RLE_ENABLE:   rle_reg     <= cfg_wdata[0];
                CFG_IMAGE_WIDTH:  width_reg   <= cfg_wdata[12:0];
                CFG_IMAGE_HEIGHT: height_reg  <= cfg_wdata[12:0];
                CFG_PALETTE_SIZE: psize_reg   <= cfg_wdata[8:0];
                default:          indexed_reg <= indexed_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            esc_phase_reg <= ESC_IDLE;
            esc_count_reg <= '0;
            run_rem_reg   <= '0;
            run_val_reg   <= '0;
            mono_byte_reg <= '0;
            mono_left_reg <= '0;
            pos_reg       <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            err_reg       <= ERR_NONE;
            done_reg      <= 1'b0;
        end
        else
        begin
            esc_phase_reg <= esc_phase_next;
            esc_count_reg <= esc_count_next;
            run_rem_reg   <= run_rem_next;
            run_val_reg   <= run_val_next;
            mono_byte_reg <= mono_byte_next;
            mono_left_reg <= mono_left_next;
            pos_reg       <= pos_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            err_reg       <= err_next;
            done_reg      <= done_next;
        end
    end

    assign pal_we    = accept && (req.func == FUNC_PAL_WRITE) &&
                       ({1'b0, req.entry_index} < PAL_SIZE_MAX);
    assign pal_waddr = req.entry_index[PAL_AW-1:0];
    assign pal_wdata = {req.entry_red, req.entry_green, req.entry_blue};
    assign pal_re    = accept && (req.func == FUNC_DATA);
    assign pal_raddr = dec_b[PAL_AW-1:0];

    assign s1_info.byte_taken  = taken;
    assign s1_info.pixel_valid = pv;
    assign s1_info.from_pal    = from_pal;
    assign s1_info.mono_white  = white;
    assign s1_info.last_pixel  = last;
    assign s1_info.error_code  = err_next;

endmodule

`default_nettype wire

// ===== rtl/sunras_out_stage.sv =====
// Palette lookup stage and output register with request flow control.
// Depends on sunras_pkg for the stage and response types.
`default_nettype none

module sunras_out_stage (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         accept,
    output logic                         in_ready,
    input  sunras_pkg::s1_t              s1_in,
    input  logic [sunras_pkg::PAL_DW-1:0] pal_rdata,
    output logic                         out_valid,
    input  logic                         out_ready,
    output sunras_pkg::rsp_t             out_rsp
);

    import sunras_pkg::*;

    logic  s1_valid_reg, s1_valid_next;
    s1_t   s1_reg;
    logic  out_valid_reg, out_valid_next;
    rsp_t  out_reg, out_next;
    logic  s1_move;
    logic [7:0] mono_level;

    assign s1_move  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_move;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_move)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (s1_move)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign mono_level = {8{s1_reg.mono_white}};

    always_comb
    begin
        out_next.byte_taken  = s1_reg.byte_taken;
        out_next.pixel_valid = s1_reg.pixel_valid;
        out_next.last_pixel  = s1_reg.last_pixel;
        out_next.error_code  = s1_reg.error_code;
        out_next.pixel_red   = '0;
        out_next.pixel_green = '0;
        out_next.pixel_blue  = '0;
        if (s1_reg.pixel_valid)
        begin
            if (s1_reg.from_pal)
            begin
                out_next.pixel_red   = pal_rdata[23:16];
                out_next.pixel_green = pal_rdata[15:8];
                out_next.pixel_blue  = pal_rdata[7:0];
            end
            else
            begin
                out_next.pixel_red   = mono_level;
                out_next.pixel_green = mono_level;
                out_next.pixel_blue  = mono_level;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg <= s1_in;
        end
        if (s1_move)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_rsp   = out_reg;

endmodule

`default_nettype wire

// ===== rtl/sun_raster_rle_pixel_decoder_top.sv =====
// Sun rasterfile RLE pixel decoder, top level.
// Uses sunras_pkg, sunras_if, sunras_decode, sunras_palette_ram, sunras_out_stage.
//
// Usage: each request on in_ch carries one command: a palette write, a data
// cycle offering at most one raster byte, a start of a new image, or an idle.
// Every request produces exactly one response on out_ch with byte_taken, at
// most one pixel, the last-pixel flag and the sticky error code. When
// byte_taken is low the source offers the same byte again in a later request.
// Configuration registers are written through cfg_we/cfg_index/cfg_wdata
// while no request is in flight.
// The response passes from the stage register (decode result, palette read data,
// both captured at the accept edge) to the output register, which presents it
// on out_ch.
// Throughput: one request per cycle while out_ch is not stalled, set by the single
// palette read port. A request is still taken while a finished response waits on
// out_ch; a stalled out_ch fills the two internal stages and then drops in_ch.ready.
// Reset: decode state and valid flags clear, registers take their defaults; the
// palette is not cleared and must be written before use.
`default_nettype none

module sun_raster_rle_pixel_decoder_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [sunras_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sunras_pkg::CFG_DATA_W-1:0] cfg_wdata,
    sunras_req_if.sink                        in_ch,
    sunras_rsp_if.source                      out_ch
);

    import sunras_pkg::*;

    logic              accept;
    logic              in_ready;
    logic              pal_we;
    logic [PAL_AW-1:0] pal_waddr;
    logic [PAL_DW-1:0] pal_wdata;
    logic              pal_re;
    logic [PAL_AW-1:0] pal_raddr;
    logic [PAL_DW-1:0] pal_rdata;
    s1_t               s1_info;

    assign accept      = in_ch.valid && in_ready;
    assign in_ch.ready = in_ready;

    sunras_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .accept    (accept),
        .req       (in_ch.payload),
        .pal_we    (pal_we),
        .pal_waddr (pal_waddr),
        .pal_wdata (pal_wdata),
        .pal_re    (pal_re),
        .pal_raddr (pal_raddr),
        .s1_info   (s1_info)
    );

    sunras_palette_ram #(
        .DEPTH (PAL_DEPTH),
        .WIDTH (PAL_DW)
    ) u_palette (
        .clk   (clk),
        .we    (pal_we),
        .waddr (pal_waddr),
        .wdata (pal_wdata),
        .re    (pal_re),
        .raddr (pal_raddr),
        .rdata (pal_rdata)
    );

    sunras_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .in_ready  (in_ready),
        .s1_in     (s1_info),
        .pal_rdata (pal_rdata),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .out_rsp   (out_ch.payload)
    );

endmodule

`default_nettype wire

// ===== rtl/sunras_checker.sv =====
// Port-level checks of the rasterfile decoder, bound to the top level.
// Depends on sunras_pkg and sun_raster_rle_pixel_decoder_top.
`default_nettype none

module sunras_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             in_ready,
    input logic             out_valid,
    input logic             out_ready,
    input sunras_pkg::rsp_t out_rsp
);

    import sunras_pkg::*;

    // no pixel: color and last flag are zero
    a_no_pixel_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_rsp.pixel_valid |->
            out_rsp.pixel_red == '0 && out_rsp.pixel_green == '0 &&
            out_rsp.pixel_blue == '0 && !out_rsp.last_pixel)
        else $error("pixel fields set without a pixel");

    // once in error, no pixel is produced
    a_err_no_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_rsp.error_code != ERR_NONE |-> !out_rsp.pixel_valid)
        else $error("pixel emitted with error set");

    // with an empty output the block must take requests
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("request blocked while output is empty");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_rsp))
        else $error("stalled response changed");

endmodule

bind sun_raster_rle_pixel_decoder_top sunras_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_rsp   (out_ch.payload)
);

`default_nettype wire
